FILE: sv/dwt_pkg.sv
// Shared types and constants for the per-id dwell time table.
`timescale 1ns / 1ps

package dwt_pkg;

	localparam int unsigned DATA_W = 64;

	localparam logic [DATA_W-1:0] DWELL_MAX = {DATA_W{1'b1}};

	// request op codes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// control of the shared add/subtract unit
	typedef struct packed {
		logic sub;
		logic carry_in;
	} alu_ctl_t;

endpackage

FILE: sv/dwt_alu.sv
// Shared 64-bit add/subtract unit with carry out, used for span and dwell sums.
`timescale 1ns / 1ps

module dwt_alu (
	input  dwt_pkg::alu_ctl_t              ctl,
	input  logic [dwt_pkg::DATA_W-1:0]     a,
	input  logic [dwt_pkg::DATA_W-1:0]     b,
	output logic [dwt_pkg::DATA_W-1:0]     result,
	output logic                           carry
);

	logic [dwt_pkg::DATA_W-1:0] b_op;
	logic [dwt_pkg::DATA_W:0]   sum;

	// subtract is a + ~b + 1; carry high then means a >= b
	assign b_op = ctl.sub ? ~b : b;
	assign sum  = {1'b0, a} + {1'b0, b_op} + {{dwt_pkg::DATA_W{1'b0}}, ctl.carry_in};

	assign result = sum[dwt_pkg::DATA_W-1:0];
	assign carry  = sum[dwt_pkg::DATA_W];

endmodule

FILE: sv/per_id_dwell_time_table.sv
// Per-id dwell time table: key search, entry update and dwell reporting.
//
// Input channel (in_valid / in_stall) carries one request: op (update or
// query), track_id, inside_req, timestamp_ns and timestamp_ok. Output
// channel (out_valid / out_stall) returns one result per request:
// dwell_total, found and table_full.
// On a request the key memory is scanned one entry per cycle with a
// registered read, from entry 0 until a hit or the last used entry.
// A hit then reads the record, and the shared adder runs the span
// subtract and the saturating dwell add in ST_SUB and ST_ADD; a miss
// goes straight to ST_DONE once every used entry has been compared.
// in_stall is high from acceptance until the result is handed to the
// output register, so one request is in flight at a time; the output
// register lets the next request be accepted while a result waits.
// If out_stall holds a result, the next result waits in its final state
// until the output register is free.
// Reset empties the table at once (entry count to zero, no clearing pass)
// and drops any request or result in flight.
`timescale 1ns / 1ps

module per_id_dwell_time_table #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [dwt_pkg::DATA_W-1:0]     track_id,
	input  logic                           inside_req,
	input  logic [dwt_pkg::DATA_W-1:0]     timestamp_ns,
	input  logic                           timestamp_ok,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dwt_pkg::DATA_W-1:0]     dwell_total,
	output logic                           found,
	output logic                           table_full
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(ENTRIES);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_LOAD = 6'b000100,
		ST_SUB  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	typedef struct packed {
		logic                       is_in;
		logic [dwt_pkg::DATA_W-1:0] entry_time;
		logic [dwt_pkg::DATA_W-1:0] dwell;
	} rec_t;

	state_t state_q;

	logic                       op_q;
	logic [dwt_pkg::DATA_W-1:0] key_q;
	logic                       inside_req_q;
	logic [dwt_pkg::DATA_W-1:0] ts_q;
	logic                       ts_ok_q;

	logic [CW-1:0] used_q;
	logic [CW-1:0] iss_q;
	logic [CW-1:0] cmp_idx_q;
	logic          cmp_v_q;
	logic [AW-1:0] slot_q;

	logic [dwt_pkg::DATA_W-1:0] key_mem [ENTRIES];
	rec_t                       rec_mem [ENTRIES];
	logic [dwt_pkg::DATA_W-1:0] key_rd_q;
	rec_t                       rec_rd_q;
	logic [dwt_pkg::DATA_W-1:0] span_q;

	logic [dwt_pkg::DATA_W-1:0] res_dwell_q;
	logic                       res_found_q;
	logic                       res_full_q;

	logic                       out_valid_q;
	logic [dwt_pkg::DATA_W-1:0] dwell_total_q;
	logic                       found_q;
	logic                       table_full_q;

	dwt_pkg::alu_ctl_t          alu_ctl;
	logic [dwt_pkg::DATA_W-1:0] alu_a;
	logic [dwt_pkg::DATA_W-1:0] alu_b;
	logic [dwt_pkg::DATA_W-1:0] alu_y;
	logic                       alu_c;

	logic                       in_acc;
	logic                       out_free;
	logic                       issue;
	logic                       hit;
	logic                       miss;
	logic                       is_update;
	logic                       alloc;
	logic [dwt_pkg::DATA_W-1:0] entry_ts;
	logic [dwt_pkg::DATA_W-1:0] sum_sat;

	logic                       key_we;
	logic                       rec_we;
	logic [AW-1:0]              rec_wa;
	rec_t                       rec_wd;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign dwell_total = dwell_total_q;
	assign found       = found_q;
	assign table_full  = table_full_q;

	assign is_update = (op_q != dwt_pkg::OP_QUERY);
	assign entry_ts  = ts_ok_q ? ts_q : '0;

	// scan: issue one key read per cycle, compare the previous read's data
	assign hit   = (state_q == ST_SCAN) && cmp_v_q && (key_rd_q == key_q);
	assign miss  = (state_q == ST_SCAN) && !cmp_v_q && !(iss_q < used_q);
	assign issue = (state_q == ST_SCAN) && !hit && (iss_q < used_q);
	assign alloc = miss && is_update && inside_req_q && (used_q < CNT_FULL);

	always_comb begin
		alu_ctl = '{sub: 1'b0, carry_in: 1'b0};
		alu_a   = rec_rd_q.dwell;
		alu_b   = span_q;
		if (state_q == ST_SUB) begin
			alu_ctl = '{sub: 1'b1, carry_in: 1'b1};
			alu_a   = ts_q;
			alu_b   = rec_rd_q.entry_time;
		end
	end

	dwt_alu u_alu (
		.ctl    (alu_ctl),
		.a      (alu_a),
		.b      (alu_b),
		.result (alu_y),
		.carry  (alu_c)
	);

	assign sum_sat = alu_c ? dwt_pkg::DWELL_MAX : alu_y;

	always_comb begin
		key_we = alloc;
		rec_we = 1'b0;
		rec_wa = slot_q;
		rec_wd = rec_rd_q;
		if (alloc) begin
			rec_we = 1'b1;
			rec_wa = used_q[AW-1:0];
			rec_wd = '{is_in: 1'b1, entry_time: entry_ts, dwell: '0};
		end else if (state_q == ST_ADD && is_update) begin
			if (inside_req_q && !rec_rd_q.is_in) begin
				rec_we = 1'b1;
				rec_wd = '{is_in: 1'b1, entry_time: entry_ts, dwell: rec_rd_q.dwell};
			end else if (!inside_req_q && rec_rd_q.is_in) begin
				rec_we = 1'b1;
				rec_wd = '{is_in: 1'b0, entry_time: rec_rd_q.entry_time,
					dwell: sum_sat};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			key_rd_q <= key_mem[iss_q[AW-1:0]];
		end
		if (key_we) begin
			key_mem[used_q[AW-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			rec_rd_q <= rec_mem[slot_q];
		end
		if (rec_we) begin
			rec_mem[rec_wa] <= rec_wd;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q         <= op;
			key_q        <= track_id;
			inside_req_q <= inside_req;
			ts_q         <= timestamp_ns;
			ts_ok_q      <= timestamp_ok;
		end
		if (issue) begin
			cmp_idx_q <= iss_q;
		end
		if (hit) begin
			slot_q <= cmp_idx_q[AW-1:0];
		end
		if (state_q == ST_SUB) begin
			span_q <= (ts_ok_q && alu_c) ? alu_y : '0;
		end
		if (miss) begin
			res_dwell_q <= '0;
			res_found_q <= alloc;
			res_full_q  <= is_update && inside_req_q && !(used_q < CNT_FULL);
		end
		if (state_q == ST_ADD) begin
			res_dwell_q <= rec_rd_q.is_in ? sum_sat : rec_rd_q.dwell;
			res_found_q <= 1'b1;
			res_full_q  <= 1'b0;
		end
		if (state_q == ST_DONE && out_free) begin
			dwell_total_q <= res_dwell_q;
			found_q       <= res_found_q;
			table_full_q  <= res_full_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			iss_q       <= '0;
			cmp_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (alloc) begin
				used_q <= used_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					iss_q   <= '0;
					cmp_v_q <= 1'b0;
					if (in_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_v_q <= issue;
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (hit) begin
						state_q <= ST_LOAD;
					end else if (miss) begin
						state_q <= ST_DONE;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_FULL)
		else $error("entry count beyond table size");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
		else $error("entry count moved by more than one");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(table_full_q && found_q))
		else $error("result both full and found");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN))
		else $error("accepted request did not start a scan");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid_q)
		else $error("finished request produced no result");
`endif

endmodule
